FILE: rtl/cfps_pkg.sv
// Shared constants for the closest and farthest pair search unit.
// Used by the top level and the distance pipeline; depends on nothing.
`default_nettype none

package cfps_pkg;

	localparam int MAX_POINTS_DEF = 1024;
	localparam int COORD_BITS_DEF = 24;
	localparam int COLOR_BITS     = 8;
	localparam int INDEX_OUT_BITS = 10;
	localparam int ROLE_BITS      = 2;

	// Order in which the four results leave the block.
	localparam logic [ROLE_BITS-1:0] ROLE_NEAR_A = 2'd0;
	localparam logic [ROLE_BITS-1:0] ROLE_NEAR_B = 2'd1;
	localparam logic [ROLE_BITS-1:0] ROLE_FAR_A  = 2'd2;
	localparam logic [ROLE_BITS-1:0] ROLE_FAR_B  = 2'd3;

	// Squared distance width: three squares of COORD_BITS-bit magnitudes.
	function automatic int dist_bits(input int coord_bits);
		return 2 * coord_bits + 2;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/closest_farthest_pair_search_unit.sv
// Closest and farthest pair search over a stored set of 3D colored points.
// Depends on cfps_pkg, cfps_ram (point store) and cfps_dist (distance pipeline).
//
//   Channel | Handshake           | Beat contents
//   --------+---------------------+-------------------------------------------------
//   in      | in_valid, in_ready  | coord_x/y/z, color_r/g/b, last_point
//   out     | out_valid, out_ready| role, point_index, out_x/y/z, out_r/g/b, last_result
//
// Points load while in_ready is high; the beat with last_point starts a walk over all
// pairs through the single read port of the point store: one pair per cycle, with a row
// read ahead of each row, then a pipeline drain. Each result beat passes an emit read,
// a capture and an output state. Input is held off from that beat until the fourth
// result is taken. Reset clears the control state only; the point store needs no
// clearing pass. A stalled output simply holds the current result beat.
`default_nettype none

module closest_farthest_pair_search_unit #(
	parameter int MAX_POINTS = cfps_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = cfps_pkg::COORD_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic signed [COORD_BITS-1:0]          coord_x,
	input  wire logic signed [COORD_BITS-1:0]          coord_y,
	input  wire logic signed [COORD_BITS-1:0]          coord_z,
	input  wire logic [cfps_pkg::COLOR_BITS-1:0]       color_r,
	input  wire logic [cfps_pkg::COLOR_BITS-1:0]       color_g,
	input  wire logic [cfps_pkg::COLOR_BITS-1:0]       color_b,
	input  wire logic                                  last_point,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [cfps_pkg::ROLE_BITS-1:0]             role,
	output logic [cfps_pkg::INDEX_OUT_BITS-1:0]        point_index,
	output logic signed [COORD_BITS-1:0]               out_x,
	output logic signed [COORD_BITS-1:0]               out_y,
	output logic signed [COORD_BITS-1:0]               out_z,
	output logic [cfps_pkg::COLOR_BITS-1:0]            out_r,
	output logic [cfps_pkg::COLOR_BITS-1:0]            out_g,
	output logic [cfps_pkg::COLOR_BITS-1:0]            out_b,
	output logic                                       last_result
);

	localparam int C     = COORD_BITS;
	localparam int CB    = cfps_pkg::COLOR_BITS;
	localparam int IW    = $clog2(MAX_POINTS);
	localparam int CW    = IW + 1;
	localparam int EW    = 3 * C + 3 * CB;
	localparam int DW    = cfps_pkg::dist_bits(COORD_BITS);
	localparam int TW    = 2 * IW;
	localparam int OFF_Z = 3 * CB;
	localparam int OFF_Y = OFF_Z + C;
	localparam int OFF_X = OFF_Y + C;

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_ROWRD = 3'd1;
	localparam logic [2:0] ST_COLRD = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_EMRD  = 3'd4;
	localparam logic [2:0] ST_EMCAP = 3'd5;
	localparam logic [2:0] ST_EMOUT = 3'd6;

	logic [2:0]    state_q;
	logic [CW-1:0] cnt_q, n_q, i_q, j_q;
	logic [CW-1:0] n_load;
	logic          full;
	logic          in_acc;
	logic [cfps_pkg::ROLE_BITS-1:0] k_q;

	logic          we;
	logic [EW-1:0] wdata, rdata;
	logic [IW-1:0] raddr, emit_addr;

	logic          v_s1, ri_s1;
	logic [TW-1:0] tag_s1;
	logic [EW-1:0] pi_q;

	logic          v_s4, dist_busy;
	logic [TW-1:0] tag_s4;
	logic [DW-1:0] dist_s4;

	logic          seeded_q;
	logic [DW-1:0] near_d_q, far_d_q;
	logic [IW-1:0] near_a_q, near_b_q, far_a_q, far_b_q;

	logic [cfps_pkg::ROLE_BITS-1:0] role_q;
	logic [IW-1:0]                  idx_q;
	logic [EW-1:0]                  pt_q;

	assign full   = (cnt_q >= CW'(MAX_POINTS));
	assign n_load = full ? cnt_q : cnt_q + 1'b1;
	assign in_ready = (state_q == ST_LOAD);
	assign in_acc   = in_valid & in_ready;

	assign we    = in_acc & ~full;
	assign wdata = {coord_x, coord_y, coord_z, color_r, color_g, color_b};

	always_comb begin
		unique case (k_q)
			cfps_pkg::ROLE_NEAR_A: emit_addr = near_a_q;
			cfps_pkg::ROLE_NEAR_B: emit_addr = near_b_q;
			cfps_pkg::ROLE_FAR_A:  emit_addr = far_a_q;
			default:               emit_addr = far_b_q;
		endcase
	end

	always_comb begin
		unique case (state_q)
			ST_ROWRD: raddr = i_q[IW-1:0];
			ST_COLRD: raddr = j_q[IW-1:0];
			default:  raddr = emit_addr;
		endcase
	end

	cfps_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_POINTS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(cnt_q[IW-1:0]),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	cfps_dist #(
		.COORD_BITS(C),
		.TAG_BITS  (TW)
	) u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_s1 (v_s1),
		.tag_s1 (tag_s1),
		.a_x    (pi_q[OFF_X +: C]),
		.a_y    (pi_q[OFF_Y +: C]),
		.a_z    (pi_q[OFF_Z +: C]),
		.b_x    (rdata[OFF_X +: C]),
		.b_y    (rdata[OFF_Y +: C]),
		.b_z    (rdata[OFF_Z +: C]),
		.vld_s4 (v_s4),
		.tag_s4 (tag_s4),
		.dist_s4(dist_s4),
		.busy   (dist_busy)
	);

	// Read issue tracking: a row read loads the fixed point of the row, a column
	// read sends a pair into the distance pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			ri_s1 <= 1'b0;
		end else begin
			v_s1  <= (state_q == ST_COLRD);
			ri_s1 <= (state_q == ST_ROWRD);
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= {i_q[IW-1:0], j_q[IW-1:0]};
		if (ri_s1) begin
			pi_q <= rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			cnt_q    <= '0;
			n_q      <= '0;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= cfps_pkg::ROLE_NEAR_A;
			seeded_q <= 1'b0;
			near_d_q <= '0;
			far_d_q  <= '0;
			near_a_q <= '0;
			near_b_q <= '0;
			far_a_q  <= '0;
			far_b_q  <= '0;
		end else begin
			// Compare stage. The first pair seeds both bests; later pairs replace
			// only when strictly better, so ties keep the earliest pair.
			if (v_s4) begin
				seeded_q <= 1'b1;
				if (!seeded_q || dist_s4 < near_d_q) begin
					near_d_q <= dist_s4;
					near_a_q <= tag_s4[TW-1 -: IW];
					near_b_q <= tag_s4[IW-1:0];
				end
				if (!seeded_q || dist_s4 > far_d_q) begin
					far_d_q <= dist_s4;
					far_a_q <= tag_s4[TW-1 -: IW];
					far_b_q <= tag_s4[IW-1:0];
				end
			end

			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (!full) begin
							cnt_q <= cnt_q + 1'b1;
						end
						if (last_point) begin
							n_q      <= n_load;
							i_q      <= '0;
							k_q      <= cfps_pkg::ROLE_NEAR_A;
							seeded_q <= 1'b0;
							near_d_q <= '0;
							far_d_q  <= '0;
							near_a_q <= '0;
							near_b_q <= '0;
							far_a_q  <= '0;
							far_b_q  <= '0;
							state_q  <= (n_load >= CW'(2)) ? ST_ROWRD : ST_EMRD;
						end
					end
				end
				ST_ROWRD: begin
					j_q     <= i_q + 1'b1;
					state_q <= ST_COLRD;
				end
				ST_COLRD: begin
					if (j_q == n_q - 1'b1) begin
						if (i_q + CW'(2) < n_q) begin
							i_q     <= i_q + 1'b1;
							state_q <= ST_ROWRD;
						end else begin
							state_q <= ST_DRAIN;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !dist_busy) begin
						state_q <= ST_EMRD;
					end
				end
				ST_EMRD: begin
					state_q <= ST_EMCAP;
				end
				ST_EMCAP: begin
					state_q <= ST_EMOUT;
				end
				ST_EMOUT: begin
					if (out_ready) begin
						if (k_q == cfps_pkg::ROLE_FAR_B) begin
							cnt_q   <= '0;
							state_q <= ST_LOAD;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_EMRD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Result register: filled from the store in the cycle after the emit read.
	always_ff @(posedge clk) begin
		if (state_q == ST_EMCAP) begin
			role_q <= k_q;
			idx_q  <= emit_addr;
			pt_q   <= rdata;
		end
	end

	assign out_valid   = (state_q == ST_EMOUT);
	assign role        = role_q;
	assign point_index = cfps_pkg::INDEX_OUT_BITS'(idx_q);
	assign out_x       = pt_q[OFF_X +: C];
	assign out_y       = pt_q[OFF_Y +: C];
	assign out_z       = pt_q[OFF_Z +: C];
	assign out_r       = pt_q[2*CB +: CB];
	assign out_g       = pt_q[CB +: CB];
	assign out_b       = pt_q[0 +: CB];
	assign last_result = (role_q == cfps_pkg::ROLE_FAR_B);

endmodule

`default_nettype wire

FILE: rtl/cfps_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module cfps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/cfps_dist.sv
// Three-stage squared Euclidean distance pipeline: difference, square, sum.
// Depends on cfps_pkg for the distance width.
`default_nettype none

module cfps_dist #(
	parameter int COORD_BITS = cfps_pkg::COORD_BITS_DEF,
	parameter int TAG_BITS   = 20
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire logic                                         vld_s1,
	input  wire logic [TAG_BITS-1:0]                          tag_s1,
	input  wire logic [COORD_BITS-1:0]                        a_x,
	input  wire logic [COORD_BITS-1:0]                        a_y,
	input  wire logic [COORD_BITS-1:0]                        a_z,
	input  wire logic [COORD_BITS-1:0]                        b_x,
	input  wire logic [COORD_BITS-1:0]                        b_y,
	input  wire logic [COORD_BITS-1:0]                        b_z,
	output logic                                              vld_s4,
	output logic [TAG_BITS-1:0]                               tag_s4,
	output logic [cfps_pkg::dist_bits(COORD_BITS)-1:0]        dist_s4,
	output logic                                              busy
);

	localparam int C  = COORD_BITS;
	localparam int DW = cfps_pkg::dist_bits(COORD_BITS);
	localparam int SW = 2 * C;

	logic          vld_s2, vld_s3;
	logic [TAG_BITS-1:0] tag_s2, tag_s3;
	logic [C-1:0]  mx_s2, my_s2, mz_s2;
	logic [SW-1:0] qx_s3, qy_s3, qz_s3;
	logic [C-1:0]  mx, my, mz;

	// The difference of two C-bit signed values fits C+1 bits signed, and its
	// magnitude fits C bits unsigned. Both directions are formed in parallel.
	function automatic logic [C-1:0] abs_diff(input logic [C-1:0] a, input logic [C-1:0] b);
		logic [C:0] ea;
		logic [C:0] eb;
		logic [C:0] dab;
		logic [C:0] dba;
		ea  = {a[C-1], a};
		eb  = {b[C-1], b};
		dab = ea - eb;
		dba = eb - ea;
		return dab[C] ? dba[C-1:0] : dab[C-1:0];
	endfunction

	assign mx = abs_diff(a_x, b_x);
	assign my = abs_diff(a_y, b_y);
	assign mz = abs_diff(a_z, b_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		tag_s2  <= tag_s1;
		mx_s2   <= mx;
		my_s2   <= my;
		mz_s2   <= mz;
		tag_s3  <= tag_s2;
		qx_s3   <= SW'(mx_s2) * SW'(mx_s2);
		qy_s3   <= SW'(my_s2) * SW'(my_s2);
		qz_s3   <= SW'(mz_s2) * SW'(mz_s2);
		tag_s4  <= tag_s3;
		dist_s4 <= DW'(qx_s3) + DW'(qy_s3) + DW'(qz_s3);
	end

	assign busy = vld_s2 | vld_s3 | vld_s4;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for closest_farthest_pair_search_unit: point sets go in on the
// input channel, and the four pair reports of each set are checked against a local search.
// Depends on cfps_pkg and the RTL of the unit; needs no files or arguments.

module testbench;

	localparam int CW          = cfps_pkg::COORD_BITS_DEF;
	localparam int STORE_DEPTH = cfps_pkg::MAX_POINTS_DEF;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_WAIT  = 64;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [cfps_pkg::COLOR_BITS-1:0] color_t;

	localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		color_t r;
		color_t g;
		color_t b;
		logic   last;
		bit     drain;
		bit     calm;
	} point_beat_t;

	typedef struct packed {
		logic [cfps_pkg::ROLE_BITS-1:0]      role;
		logic [cfps_pkg::INDEX_OUT_BITS-1:0] index;
		coord_t x;
		coord_t y;
		coord_t z;
		color_t r;
		color_t g;
		color_t b;
		logic   last;
	} pair_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	coord_t coord_x = '0;
	coord_t coord_y = '0;
	coord_t coord_z = '0;
	color_t color_r = '0;
	color_t color_g = '0;
	color_t color_b = '0;
	logic last_point = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [cfps_pkg::ROLE_BITS-1:0] role;
	logic [cfps_pkg::INDEX_OUT_BITS-1:0] point_index;
	coord_t out_x;
	coord_t out_y;
	coord_t out_z;
	color_t out_r;
	color_t out_g;
	color_t out_b;
	logic last_result;

	point_beat_t  pending_points[$];
	pair_report_t reports_due[$];
	point_beat_t  held_points [0:STORE_DEPTH-1];
	int           held_count = 0;
	logic         in_taken = 1'b0;
	bit           calm_now = 1'b0;
	bit           calm_fill = 1'b0;
	bit           drain_next = 1'b0;
	int           fault_count = 0;
	int           cycle_count = 0;

	closest_farthest_pair_search_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.coord_z     (coord_z),
		.color_r     (color_r),
		.color_g     (color_g),
		.color_b     (color_b),
		.last_point  (last_point),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.role        (role),
		.point_index (point_index),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_z       (out_z),
		.out_r       (out_r),
		.out_g       (out_g),
		.out_b       (out_b),
		.last_result (last_result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint sq_gap(input coord_t a, input coord_t b);
		longint d;
		d = longint'(a) - longint'(b);
		return d * d;
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(9))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2, 3, 4: return coord_t'($urandom);
			5: return coord_t'($urandom_range(3));
			default: return coord_t'(int'($urandom_range(8191)) - 4096);
		endcase
	endfunction

	function automatic string report_text(input pair_report_t p);
		return $sformatf("role %0d idx %0d xyz %0d %0d %0d rgb %0d %0d %0d last %0b",
			p.role, p.index, p.x, p.y, p.z, p.r, p.g, p.b, p.last);
	endfunction

	task automatic push_point(input coord_t x, input coord_t y, input coord_t z,
			input color_t r, input color_t g, input color_t b, input logic last);
		point_beat_t p;
		p.x = x;
		p.y = y;
		p.z = z;
		p.r = r;
		p.g = g;
		p.b = b;
		p.last = last;
		p.drain = drain_next;
		p.calm = calm_fill;
		drain_next = 1'b0;
		pending_points.push_back(p);
	endtask

	task automatic queue_report(input logic [cfps_pkg::ROLE_BITS-1:0] which, input int idx);
		pair_report_t rep;
		rep.role = which;
		rep.index = idx[cfps_pkg::INDEX_OUT_BITS-1:0];
		rep.x = held_points[idx].x;
		rep.y = held_points[idx].y;
		rep.z = held_points[idx].z;
		rep.r = held_points[idx].r;
		rep.g = held_points[idx].g;
		rep.b = held_points[idx].b;
		rep.last = (which == cfps_pkg::ROLE_FAR_B);
		reports_due.push_back(rep);
	endtask

	// Point beats are launched at the falling edge; a beat stays up until it is taken.
	always @(negedge clk) begin
		point_beat_t beat;
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (pending_points.size() != 0
						&& !(pending_points[0].drain && reports_due.size() != 0)
						&& (pending_points[0].calm || $urandom_range(99) >= 24)) begin
					beat = pending_points.pop_front();
					calm_now = beat.calm;
					coord_x <= beat.x;
					coord_y <= beat.y;
					coord_z <= beat.z;
					color_r <= beat.r;
					color_g <= beat.g;
					color_b <= beat.b;
					last_point <= beat.last;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= calm_now || ($urandom_range(99) >= 24);
		end
	end

	// Accepted point beats feed the local store; a closing beat runs the pair search.
	always @(posedge clk) begin : take_points
		int i;
		int j;
		longint d;
		longint near_d;
		longint far_d;
		int near_a;
		int near_b;
		int far_a;
		int far_b;
		in_taken <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			// A point that finds the store full is dropped, but its last flag still counts.
			if (held_count < STORE_DEPTH) begin
				held_points[held_count].x = coord_x;
				held_points[held_count].y = coord_y;
				held_points[held_count].z = coord_z;
				held_points[held_count].r = color_r;
				held_points[held_count].g = color_g;
				held_points[held_count].b = color_b;
				held_count++;
			end
			if (last_point) begin
				near_d = 0;
				far_d = 0;
				near_a = 0;
				near_b = 0;
				far_a = 0;
				far_b = 0;
				for (i = 0; i + 1 < held_count; i++) begin
					for (j = i + 1; j < held_count; j++) begin
						d = sq_gap(held_points[i].x, held_points[j].x)
							+ sq_gap(held_points[i].y, held_points[j].y)
							+ sq_gap(held_points[i].z, held_points[j].z);
						if (i == 0 && j == 1) begin
							near_d = d;
							far_d = d;
							near_b = 1;
							far_b = 1;
						end else begin
							// Strict tests, so a tie keeps the earlier pair.
							if (d < near_d) begin
								near_d = d;
								near_a = i;
								near_b = j;
							end
							if (d > far_d) begin
								far_d = d;
								far_a = i;
								far_b = j;
							end
						end
					end
				end
				queue_report(cfps_pkg::ROLE_NEAR_A, near_a);
				queue_report(cfps_pkg::ROLE_NEAR_B, near_b);
				queue_report(cfps_pkg::ROLE_FAR_A, far_a);
				queue_report(cfps_pkg::ROLE_FAR_B, far_b);
				held_count = 0;
			end
		end
	end

	always @(posedge clk) begin : take_reports
		pair_report_t got;
		pair_report_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {role, point_index, out_x, out_y, out_z, out_r, out_g, out_b, last_result};
			if (reports_due.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected report beat: role %0d index %0d", role, point_index);
			end else begin
				want = reports_due.pop_front();
				if (got !== want) begin
					fault_count++;
					if (fault_count <= 10)
						$display("report mismatch: expected %s; got %s",
							report_text(want), report_text(got));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stimulus
		int n;
		int k;
		int made;
		int set_no;

		// Lone point: no pair exists, so every report names point 0.
		push_point(COORD_MAX, COORD_MAX, COORD_MAX, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		push_point(COORD_MIN, COORD_MIN, COORD_MIN, 8'h00, 8'h00, 8'h00, 1'b1);
		// Opposite corners give the widest distance the coordinates allow.
		push_point(COORD_MAX, COORD_MAX, COORD_MAX, 8'hFF, 8'h00, 8'hFF, 1'b0);
		push_point(COORD_MIN, COORD_MIN, COORD_MIN, 8'h00, 8'hFF, 8'h00, 1'b1);
		// Identical points: every pair ties at zero, so both bests stay on the first pair.
		for (k = 0; k < 3; k++)
			push_point(coord_t'(-300), coord_t'(77), coord_t'(5), 8'h5A, 8'hA5, color_t'(k),
				k == 2);
		// Evenly spaced on a line: nearest ties, farthest is the two ends.
		for (k = 0; k < 4; k++)
			push_point(coord_t'(256 * k), '0, '0, color_t'(k), 8'h80, 8'h01, k == 3);
		// Both bests move away from the seeding pair, to different later pairs.
		push_point(coord_t'(1000), '0, '0, 8'h10, 8'h20, 8'h30, 1'b0);
		push_point(COORD_MIN, '0, '0, 8'h11, 8'h21, 8'h31, 1'b0);
		push_point(COORD_MAX, '0, '0, 8'h12, 8'h22, 8'h32, 1'b0);
		push_point(coord_t'(5), coord_t'(5), coord_t'(5), 8'h13, 8'h23, 8'h33, 1'b0);
		push_point(coord_t'(6), coord_t'(5), coord_t'(5), 8'h14, 8'h24, 8'h34, 1'b1);
		push_point('0, COORD_MIN, COORD_MAX, 8'hC0, 8'h0C, 8'hFF, 1'b0);
		push_point('0, COORD_MAX, COORD_MIN, 8'h03, 8'h30, 8'h00, 1'b0);
		push_point(coord_t'(-1), coord_t'(-1), coord_t'(-1), 8'hFF, 8'hFF, 8'h00, 1'b1);

		// Random sets; the first waits for the directed reports, a few run with no idling.
		drain_next = 1'b1;
		made = 0;
		set_no = 0;
		while (made < 100) begin
			case ($urandom_range(9))
				0: n = 1;
				8: n = $urandom_range(20, 12);
				9: n = 2;
				default: n = $urandom_range(8, 2);
			endcase
			calm_fill = (set_no >= 5 && set_no < 10);
			for (k = 0; k < n; k++)
				push_point(rand_coord(), rand_coord(), rand_coord(), color_t'($urandom_range(255)),
					color_t'($urandom_range(255)), color_t'($urandom_range(255)), k == n - 1);
			made += n;
			set_no++;
		end
		calm_fill = 1'b0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_points.size() != 0 || in_valid)
			@(posedge clk);
		while (reports_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (fault_count == 0 && reports_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
